>>> rtl/avi_pkg.sv
// Shared types and constants for the accelerometer velocity integrator.
`timescale 1ns / 1ps

package avi_pkg;

  localparam int VEL_WIDTH = 48;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // magnitude squaring: velocity split into CHUNK-bit pieces
  localparam int CHUNK     = 24;
  localparam int NCH       = (VEL_WIDTH + CHUNK - 1) / CHUNK;
  localparam int NCH_IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SQ_W      = 2 * CHUNK * NCH;

  // speed unit
  localparam int SPD_CNT_W = $clog2(VEL_WIDTH + 1);
  localparam int SPD_Q_W   = VEL_WIDTH - 6;
  localparam int DIV_CONST = 625;
  // floor(n / 625) = (n * SPD_RECIP) >> SPD_SH, exact for n below 2^SPD_Q_W
  localparam int SPD_SH    = SPD_Q_W + 10;
  localparam logic [SPD_Q_W:0] SPD_RECIP =
    (SPD_Q_W+1)'(((128'd1 << SPD_SH) + 128'(DIV_CONST - 1)) / 128'(DIV_CONST));

  localparam int FILT_W   = 24;
  localparam int STILL_W  = 17;
  localparam int ONE_G    = 65536;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = ((3 * VEL_WIDTH + 32 + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILLNESS_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_TIME_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELAPSED_MS   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FA, ST_FB, ST_FC,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3,
    ST_VX, ST_VY, ST_VZ,
    ST_MI, ST_MA, ST_SPD_GO, ST_SPD_WAIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SP_IDLE, SP_ROOT, SP_PREP, SP_DIV, SP_FIN
  } spd_state_t;

endpackage

>>> rtl/avi_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module avi_mul (
  input  logic                               clk,
  input  logic signed [avi_pkg::MUL_W-1:0]   a,
  input  logic signed [avi_pkg::MUL_W-1:0]   b,
  output logic signed [avi_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> rtl/avi_speed.sv
// Speed unit: bit-serial square root, then reciprocal multiply, km/h out.
`timescale 1ns / 1ps

module avi_speed (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2*avi_pkg::VEL_WIDTH-1:0]   msq,
  output logic                              done,
  output logic [31:0]                       speed
);

  localparam int VW    = avi_pkg::VEL_WIDTH;
  localparam int REM_W = VW + 4;
  localparam int QW    = avi_pkg::SPD_Q_W;
  // reciprocal product done as four partial products
  localparam int HN    = (QW + 1) / 2;
  localparam int HM    = (QW + 2) / 2;
  localparam int AW    = 2 * (HN + HM);

  avi_pkg::spd_state_t state, state_next;

  logic [2*VW-1:0]                m_sh;
  logic [REM_W-1:0]               rem;
  logic [VW-1:0]                  root;
  logic [avi_pkg::SPD_CNT_W-1:0]  cnt;
  logic [QW-1:0]                  num;
  logic [AW-1:0]                  acc;

  logic [REM_W-1:0] rem_sh, trial;
  logic [VW+3:0]    nine_r;
  logic [2*HN-1:0]  n_pad;
  logic [2*HM-1:0]  m_pad;
  logic [HN-1:0]    n_part;
  logic [HM-1:0]    m_part;
  logic [HN+HM-1:0] pp;
  logic [AW-1:0]    pp_sh;
  logic [63:0]      q64;

  always_comb begin
    rem_sh  = {rem[REM_W-3:0], m_sh[2*VW-1 -: 2]};
    trial   = REM_W'({root, 2'b01});
    nine_r  = (VW+4)'({root, 3'b000}) + (VW+4)'(root);
    n_pad   = (2*HN)'(num);
    m_pad   = (2*HM)'(avi_pkg::SPD_RECIP);
    n_part  = cnt[1] ? n_pad[2*HN-1 -: HN] : n_pad[HN-1:0];
    m_part  = cnt[0] ? m_pad[2*HM-1 -: HM] : m_pad[HM-1:0];
    pp      = (HN+HM)'(n_part) * (HN+HM)'(m_part);
    pp_sh   = AW'(pp) << ((cnt[1] ? HN : 0) + (cnt[0] ? HM : 0));
    q64     = 64'(acc >> avi_pkg::SPD_SH);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      avi_pkg::SP_IDLE: if (start) state_next = avi_pkg::SP_ROOT;
      avi_pkg::SP_ROOT: if (cnt == avi_pkg::SPD_CNT_W'(VW - 1)) state_next = avi_pkg::SP_PREP;
      avi_pkg::SP_PREP: state_next = avi_pkg::SP_DIV;
      avi_pkg::SP_DIV:  if (cnt == avi_pkg::SPD_CNT_W'(3)) state_next = avi_pkg::SP_FIN;
      avi_pkg::SP_FIN:  state_next = avi_pkg::SP_IDLE;
      default:          state_next = avi_pkg::SP_IDLE;
    endcase
  end

  always_comb begin
    done = (state == avi_pkg::SP_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avi_pkg::SP_IDLE;
      speed <= '0;
    end else begin
      state <= state_next;
      case (state)
        avi_pkg::SP_IDLE: begin
          m_sh <= msq;
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end
        avi_pkg::SP_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[VW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[VW-2:0], 1'b0};
          end
          m_sh <= {m_sh[2*VW-3:0], 2'b00};
          cnt  <= cnt + 1'b1;
        end
        avi_pkg::SP_PREP: begin
          // floor(9r / 640000) = floor(floor(9r / 1024) / 625)
          num <= nine_r[VW+3:10];
          acc <= '0;
          cnt <= '0;
        end
        avi_pkg::SP_DIV: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 1'b1;
        end
        avi_pkg::SP_FIN: begin
          speed <= (q64 > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q64[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/accel_velocity_integrator_top.sv
// Top level: accelerometer velocity integrator with stillness recalibration.
`timescale 1ns / 1ps

// Takes one sample per input transfer and returns one result transfer per sample.
// A capture command (tuser high) or a sample whose elapsed time is zero or above
// max_elapsed_ms goes from idle straight to the done state. A processed sample
// runs through one shared 25x25 multiplier under the sequencer (filter, motion
// test and integration, velocity squares) and then the speed unit, with its
// bit-serial square root and four-step reciprocal multiply for the km/h scaling.
// The input is ready only in idle;
// a finished result sits in the output register, so the next sample is taken
// while the last result waits. Velocities are Q16 g*ms, saturating; speed is
// km/h with 8 fraction bits. Configuration writes are taken at any time but
// should land only while idle.
module accel_velocity_integrator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [avi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [avi_pkg::CFG_DATA_W-1:0]       cfg_data,
  // sample in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [avi_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // raw_x, raw_y, raw_z, elapsed_ms
  input  logic                                 s_axis_tuser,  // cmd
  // result out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [avi_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // vel_x, vel_y, vel_z, ground_speed
  output logic [1:0]                           m_axis_tuser   // accepted, recalibrated
);

  localparam int VW     = avi_pkg::VEL_WIDTH;
  localparam int FW     = avi_pkg::FILT_W;
  localparam int MW     = avi_pkg::MUL_W;
  localparam int PW     = avi_pkg::PROD_W;
  localparam int SUM_W  = ((VW > PW) ? VW : PW) + 1;
  localparam int NIW    = avi_pkg::NCH_IDX_W;

  // configuration registers
  logic [15:0] smoothing_weight;
  logic [17:0] deadzone_level;
  logic [17:0] stillness_level;
  logic [15:0] still_time_ms;
  logic [15:0] max_elapsed_ms;

  // block state
  logic signed [7:0]    axis_offset [3];
  logic signed [FW-1:0] prev_filtered [3];
  logic signed [VW-1:0] velocity [3];
  logic [avi_pkg::STILL_W-1:0] still_elapsed;

  // per-sample working registers
  avi_pkg::state_t state, state_next;
  logic signed [7:0]    raw [3];
  logic [15:0]          ms;
  logic [1:0]           axis;
  logic signed [FW-1:0] filt [3];
  logic signed [PW-1:0] facc;
  logic                 moving;
  logic                 still;
  logic                 acc_flag;
  logic                 recal_flag;
  logic                 mag_ax;
  logic [NIW-1:0]       mag_j, mag_k;
  logic [avi_pkg::SQ_W-1:0] msq;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  // speed unit
  logic        spd_start, spd_done;
  logic [31:0] speed;

  logic in_fire, out_free, ignore;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign ignore   = (s_axis_tdata[39:24] == 16'd0) || (s_axis_tdata[39:24] > max_elapsed_ms);

  avi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  avi_speed u_speed (
    .clk   (clk),
    .rst   (rst),
    .start (spd_start),
    .msq   (msq[2*VW-1:0]),
    .done  (spd_done),
    .speed (speed)
  );

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] v,
                                                  input logic signed [PW-1:0] p);
    logic signed [SUM_W-1:0] s, hi, lo;
    s  = SUM_W'(v) + SUM_W'(p);
    hi = SUM_W'($signed({1'b0, {(VW-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (s > hi)      sat_add = hi[VW-1:0];
    else if (s < lo) sat_add = lo[VW-1:0];
    else             sat_add = s[VW-1:0];
  endfunction

  // datapath helpers
  logic signed [8:0]      diff_raw;
  logic signed [18:0]     accel;
  logic signed [PW:0]     fsum;
  logic signed [PW-16:0]  fshift;
  logic signed [FW-1:0]   fsat;
  logic signed [FW:0]     dx, dy, dz;
  logic [FW:0]            adx, ady, adz;
  logic [FW+1:0]          change;
  logic [FW-1:0]          af0, af1;
  logic signed [FW-1:0]   f2c;
  logic [17:0]            se_sum;
  logic [avi_pkg::STILL_W-1:0] se_sat;
  logic                   recal_now;
  logic signed [VW-1:0]   vsel;
  logic [VW-1:0]          vabs;
  logic [avi_pkg::CHUNK*avi_pkg::NCH-1:0] vpad;
  logic [avi_pkg::CHUNK-1:0] chunk_j, chunk_k;
  logic [avi_pkg::SQ_W-1:0]  part_sh;

  always_comb begin
    diff_raw = 9'(raw[axis]) - 9'(axis_offset[axis]);
    accel    = {diff_raw, 10'd0};
    fsum     = (PW+1)'(facc) + (PW+1)'(prod) + (PW+1)'(32768);
    fshift   = fsum[PW:16];
    if (fshift > (PW-15)'($signed({1'b0, {(FW-1){1'b1}}})))
      fsat = {1'b0, {(FW-1){1'b1}}};
    else if (fshift < -(PW-15)'($signed({1'b0, {(FW-1){1'b1}}})) - (PW-15)'(1))
      fsat = {1'b1, {(FW-1){1'b0}}};
    else
      fsat = fshift[FW-1:0];

    dx     = (FW+1)'(filt[0]) - (FW+1)'(prev_filtered[0]);
    dy     = (FW+1)'(filt[1]) - (FW+1)'(prev_filtered[1]);
    dz     = (FW+1)'(filt[2]) - (FW+1)'(avi_pkg::ONE_G);
    adx    = dx[FW] ? -dx : dx;
    ady    = dy[FW] ? -dy : dy;
    adz    = dz[FW] ? -dz : dz;
    change = (FW+2)'(adx) + (FW+2)'(ady);
    af0    = filt[0][FW-1] ? -filt[0] : filt[0];
    af1    = filt[1][FW-1] ? -filt[1] : filt[1];
    f2c    = (adz < (FW+1)'(deadzone_level)) ? FW'(avi_pkg::ONE_G) : filt[2];

    se_sum    = 18'(still_elapsed) + 18'(ms);
    se_sat    = se_sum[17] ? '1 : se_sum[avi_pkg::STILL_W-1:0];
    recal_now = still && (se_sat > avi_pkg::STILL_W'(still_time_ms));

    vsel    = mag_ax ? velocity[1] : velocity[0];
    vabs    = vsel[VW-1] ? -vsel : vsel;
    vpad    = (avi_pkg::CHUNK*avi_pkg::NCH)'(vabs);
    chunk_j = vpad[mag_j*avi_pkg::CHUNK +: avi_pkg::CHUNK];
    chunk_k = vpad[mag_k*avi_pkg::CHUNK +: avi_pkg::CHUNK];
    part_sh = avi_pkg::SQ_W'(prod[2*avi_pkg::CHUNK-1:0])
              << (avi_pkg::CHUNK * (32'(mag_j) + 32'(mag_k)));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      avi_pkg::ST_IDLE:
        if (in_fire) state_next = (s_axis_tuser || ignore) ? avi_pkg::ST_DONE : avi_pkg::ST_FA;
      avi_pkg::ST_FA:  state_next = avi_pkg::ST_FB;
      avi_pkg::ST_FB:  state_next = avi_pkg::ST_FC;
      avi_pkg::ST_FC:  state_next = (axis == 2'd2) ? avi_pkg::ST_SQ0 : avi_pkg::ST_FA;
      avi_pkg::ST_SQ0: state_next = avi_pkg::ST_SQ1;
      avi_pkg::ST_SQ1: state_next = avi_pkg::ST_SQ2;
      avi_pkg::ST_SQ2: state_next = avi_pkg::ST_SQ3;
      avi_pkg::ST_SQ3: state_next = avi_pkg::ST_VX;
      avi_pkg::ST_VX:  state_next = avi_pkg::ST_VY;
      avi_pkg::ST_VY:  state_next = avi_pkg::ST_VZ;
      avi_pkg::ST_VZ:  state_next = avi_pkg::ST_MI;
      avi_pkg::ST_MI:  state_next = avi_pkg::ST_MA;
      avi_pkg::ST_MA:
        if (mag_ax && mag_j == NIW'(avi_pkg::NCH - 1) && mag_k == NIW'(avi_pkg::NCH - 1))
          state_next = avi_pkg::ST_SPD_GO;
        else
          state_next = avi_pkg::ST_MI;
      avi_pkg::ST_SPD_GO:   state_next = avi_pkg::ST_SPD_WAIT;
      avi_pkg::ST_SPD_WAIT: if (spd_done) state_next = avi_pkg::ST_DONE;
      avi_pkg::ST_DONE:     if (out_free) state_next = avi_pkg::ST_IDLE;
      default:              state_next = avi_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, handshake, speed start
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    s_axis_tready = (state == avi_pkg::ST_IDLE);
    spd_start     = (state == avi_pkg::ST_SPD_GO);
    unique case (state)
      avi_pkg::ST_FA: begin
        mul_a = MW'(prev_filtered[axis]);
        mul_b = MW'({1'b0, smoothing_weight});
      end
      avi_pkg::ST_FB: begin
        mul_a = MW'(accel);
        mul_b = MW'({1'b0, 17'(avi_pkg::ONE_G) - 17'(smoothing_weight)});
      end
      avi_pkg::ST_SQ0: begin mul_a = MW'(filt[0]); mul_b = MW'(filt[0]); end
      avi_pkg::ST_SQ1: begin mul_a = MW'(filt[1]); mul_b = MW'(filt[1]); end
      avi_pkg::ST_SQ2: begin
        mul_a = MW'({1'b0, deadzone_level});
        mul_b = MW'({1'b0, deadzone_level});
      end
      avi_pkg::ST_SQ3: begin mul_a = MW'(filt[0]); mul_b = MW'({1'b0, ms}); end
      avi_pkg::ST_VX:  begin mul_a = MW'(filt[1]); mul_b = MW'({1'b0, ms}); end
      avi_pkg::ST_VY:  begin mul_a = MW'(f2c);     mul_b = MW'({1'b0, ms}); end
      avi_pkg::ST_MI:  begin mul_a = MW'({1'b0, chunk_j}); mul_b = MW'({1'b0, chunk_k}); end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= 16'd13107;
      deadzone_level   <= 18'd5243;
      stillness_level  <= 18'd3277;
      still_time_ms    <= 16'd70;
      max_elapsed_ms   <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avi_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[15:0];
        avi_pkg::REG_DEADZONE_LEVEL:   deadzone_level   <= cfg_data;
        avi_pkg::REG_STILLNESS_LEVEL:  stillness_level  <= cfg_data;
        avi_pkg::REG_STILL_TIME_MS:    still_time_ms    <= cfg_data[15:0];
        avi_pkg::REG_MAX_ELAPSED_MS:   max_elapsed_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= avi_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      still_elapsed <= '0;
      for (int i = 0; i < 3; i++) begin
        axis_offset[i]   <= '0;
        prev_filtered[i] <= '0;
        velocity[i]      <= '0;
      end
    end else begin
      state <= state_next;
      if (state == avi_pkg::ST_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready)   m_axis_tvalid <= 1'b0;
      case (state)
        avi_pkg::ST_IDLE: begin
          if (in_fire) begin
            raw[0]     <= s_axis_tdata[7:0];
            raw[1]     <= s_axis_tdata[15:8];
            raw[2]     <= s_axis_tdata[23:16];
            ms         <= s_axis_tdata[39:24];
            axis       <= '0;
            acc_flag   <= !s_axis_tuser && !ignore;
            recal_flag <= 1'b0;
            if (s_axis_tuser) begin
              axis_offset[0] <= s_axis_tdata[7:0];
              axis_offset[1] <= s_axis_tdata[15:8];
              axis_offset[2] <= s_axis_tdata[23:16];
            end
          end
        end
        avi_pkg::ST_FB:  facc <= prod;
        avi_pkg::ST_FC: begin
          filt[axis] <= fsat;
          axis       <= axis + 2'd1;
        end
        avi_pkg::ST_SQ1: facc <= prod;
        avi_pkg::ST_SQ2: facc <= facc + prod;
        avi_pkg::ST_SQ3: moving <= (facc > prod);
        avi_pkg::ST_VX:  if (moving) velocity[0] <= sat_add(velocity[0], prod);
        avi_pkg::ST_VY: begin
          if (moving) begin
            velocity[1] <= sat_add(velocity[1], prod);
          end else begin
            velocity[0] <= '0;
            velocity[1] <= '0;
            velocity[2] <= '0;
          end
          still   <= (change < (FW+2)'(stillness_level));
          // dead-zone clamp, z snaps to 1 g
          if (af0 < FW'(deadzone_level)) filt[0] <= '0;
          if (af1 < FW'(deadzone_level)) filt[1] <= '0;
          filt[2] <= f2c;
        end
        avi_pkg::ST_VZ: begin
          for (int i = 0; i < 3; i++) prev_filtered[i] <= filt[i];
          if (recal_now) begin
            // stillness timeout: recapture offsets, clear all velocities
            for (int i = 0; i < 3; i++) begin
              axis_offset[i] <= raw[i];
              velocity[i]    <= '0;
            end
            still_elapsed <= '0;
            recal_flag    <= 1'b1;
          end else begin
            velocity[2]   <= sat_add(velocity[2], prod);
            still_elapsed <= still ? se_sat : '0;
          end
          mag_ax <= 1'b0;
          mag_j  <= '0;
          mag_k  <= '0;
          msq    <= '0;
        end
        avi_pkg::ST_MA: begin
          msq <= msq + part_sh;
          if (mag_k == NIW'(avi_pkg::NCH - 1)) begin
            mag_k <= '0;
            if (mag_j == NIW'(avi_pkg::NCH - 1)) begin
              mag_j  <= '0;
              mag_ax <= 1'b1;
            end else begin
              mag_j <= mag_j + 1'b1;
            end
          end else begin
            mag_k <= mag_k + 1'b1;
          end
        end
        avi_pkg::ST_DONE: begin
          if (out_free) begin
            m_axis_tdata  <= avi_pkg::OUT_TDATA_W'({speed, velocity[2], velocity[1],
                                                    velocity[0]});
            m_axis_tuser  <= {recal_flag, acc_flag};
          end
        end
        default: ;
      endcase
    end
  end

  // recalibration only ever follows an accepted sample
  a_recal_acc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("recalibrated without accepted");

  // recalibration leaves all velocities at zero
  a_recal_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[3*VW-1:0] == '0))
    else $error("velocity not cleared on recalibration");

  // speed unit idle whenever the sequencer is idle
  a_spd_idle: assert property (@(posedge clk) disable iff (rst)
    (state == avi_pkg::ST_IDLE) |-> !spd_done)
    else $error("speed unit active while idle");

  // a result is loaded only from the done state
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == avi_pkg::ST_DONE)
    else $error("result loaded outside done state");

endmodule
